FILE: design/esfc_pkg.sv
// esfc_pkg: types, field widths and register codes for the entity sphere frustum cull
// no dependencies; imported by design/entity_sphere_frustum_cull.sv

package esfc_pkg;

  // number of frustum planes that are tested, and the register slots provided
  localparam int NUM_PLANES = 4;
  localparam int MAX_PLANES = 4;

  // field widths
  localparam int COORD_W  = 24;  // signed Q15.8
  localparam int RAD_W    = 23;  // unsigned Q15.8
  localparam int KIND_W   = 2;
  localparam int NORM_W   = 13;  // signed Q1.11
  localparam int DIST_W   = 24;  // signed Q15.8
  localparam int FRAC_SH  = 11;  // normal fraction bits, aligns Q15.8 to Q.19
  localparam int PLANE_W  = 3 * NORM_W + DIST_W;
  localparam int CFG_W    = PLANE_W;
  localparam int REG_IDX_W = 3;
  localparam int CLIP_W   = MAX_PLANES;

  // plane register bit positions
  localparam int NX_LSB = 0;
  localparam int NY_LSB = NORM_W;
  localparam int NZ_LSB = 2 * NORM_W;
  localparam int D_LSB  = 3 * NORM_W;

  // arithmetic widths
  localparam int PROD_W = COORD_W + NORM_W;            // one centre * normal product
  localparam int LHS_W  = PROD_W + 3;                  // three products minus scaled dist
  localparam int THR_W  = RAD_W + FRAC_SH + 1;         // scaled radius, signed
  localparam int CMP_W  = LHS_W + 1;                   // lhs plus scaled radius

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_PLANE_0     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PLANE_1     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PLANE_2     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PLANE_3     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CLIP_MASK   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CULL_DIS    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_NONVIEWER   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPECIAL     = 3'd7;

  // register reset values
  localparam logic [CLIP_W-1:0] CLIP_MASK_RST = '1;

  // model kind flag bits
  localparam int KIND_VIEW_BIT   = 0;
  localparam int KIND_PLAYER_BIT = 1;

  // cull reasons
  typedef enum logic [1:0] {
    REASON_NONE         = 2'd0,
    REASON_VIEW_MODEL   = 2'd1,
    REASON_PLAYER_MODEL = 2'd2,
    REASON_FRUSTUM      = 2'd3
  } reason_e;

  // input transaction
  typedef struct packed {
    logic signed [COORD_W-1:0] centre_x;
    logic signed [COORD_W-1:0] centre_y;
    logic signed [COORD_W-1:0] centre_z;
    logic [RAD_W-1:0]          sphere_radius;
    logic [KIND_W-1:0]         model_kind;
  } esfc_in_t;

  // result transaction
  typedef struct packed {
    logic       culled;
    logic [1:0] cull_reason;
  } esfc_out_t;

endpackage

FILE: design/entity_sphere_frustum_cull.sv
// entity_sphere_frustum_cull: three-stage pipelined sphere versus frustum cull
// depends on design/esfc_pkg.sv
// a result strobe follows its start through the multiply, sum and compare stages
// throughput: one entity per cycle; busy_o is low except in the first cycle after reset
// reset: rst_ni async active low clears pipeline valids and loads register defaults
// the receiver cannot stall, so results leave on done_o without back-pressure

module entity_sphere_frustum_cull (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  esfc_pkg::esfc_in_t                in_i,
  output logic                              done_o,
  output esfc_pkg::esfc_out_t               res_o,
  input  logic                              cfg_we_i,
  input  logic [esfc_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  logic [esfc_pkg::CFG_W-1:0]        cfg_data_i
);
  import esfc_pkg::*;

  // configuration registers
  logic [PLANE_W-1:0] plane_q [MAX_PLANES];
  logic [CLIP_W-1:0]  clip_mask_q;
  logic               cull_dis_q;
  logic               nonviewer_q;
  logic               special_q;

  // pipeline registers
  logic                     busy_q;
  logic                     v1_q, v2_q, done_q;
  logic signed [PROD_W-1:0] prod_d [NUM_PLANES][3];
  logic signed [PROD_W-1:0] prod_q [NUM_PLANES][3];
  logic [RAD_W-1:0]         rad1_q, rad2_q;
  logic [KIND_W-1:0]        kind1_q, kind2_q;
  logic signed [LHS_W-1:0]  lhs_d [NUM_PLANES];
  logic signed [LHS_W-1:0]  lhs_q [NUM_PLANES];
  esfc_out_t                res_d, res_q;
  logic                     accept;

  assign accept = start_i && !busy_q;
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < MAX_PLANES; p++) begin
        plane_q[p] <= '0;
      end
      clip_mask_q <= CLIP_MASK_RST;
      cull_dis_q  <= 1'b0;
      nonviewer_q <= 1'b0;
      special_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PLANE_0:   plane_q[0]  <= cfg_data_i[PLANE_W-1:0];
        REG_PLANE_1:   plane_q[1]  <= cfg_data_i[PLANE_W-1:0];
        REG_PLANE_2:   plane_q[2]  <= cfg_data_i[PLANE_W-1:0];
        REG_PLANE_3:   plane_q[3]  <= cfg_data_i[PLANE_W-1:0];
        REG_CLIP_MASK: clip_mask_q <= cfg_data_i[CLIP_W-1:0];
        REG_CULL_DIS:  cull_dis_q  <= cfg_data_i[0];
        REG_NONVIEWER: nonviewer_q <= cfg_data_i[0];
        REG_SPECIAL:   special_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage 1: centre times each plane normal
  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      prod_d[p][0] = in_i.centre_x * $signed(plane_q[p][NX_LSB +: NORM_W]);
      prod_d[p][1] = in_i.centre_y * $signed(plane_q[p][NY_LSB +: NORM_W]);
      prod_d[p][2] = in_i.centre_z * $signed(plane_q[p][NZ_LSB +: NORM_W]);
    end
  end

  // stage 2: dot product minus scaled distance
  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      lhs_d[p] = LHS_W'(prod_q[p][0]) + LHS_W'(prod_q[p][1]) + LHS_W'(prod_q[p][2])
               - (LHS_W'($signed(plane_q[p][D_LSB +: DIST_W])) <<< FRAC_SH);
    end
  end

  // stage 3: plane test against scaled radius and the model kind rules
  always_comb begin
    logic signed [THR_W-1:0] thr;
    logic signed [CMP_W-1:0] side;
    logic                    outside;
    thr     = $signed({1'b0, rad2_q, {FRAC_SH{1'b0}}});
    outside = 1'b0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      side = CMP_W'(lhs_q[p]) + CMP_W'(thr);
      if (clip_mask_q[p] && (side <= 0)) begin
        outside = 1'b1;
      end
    end
    if (cull_dis_q) begin
      outside = 1'b0;
    end
    res_d.culled      = 1'b0;
    res_d.cull_reason = REASON_NONE;
    if (kind2_q[KIND_VIEW_BIT]) begin
      if (nonviewer_q) begin
        res_d.culled      = 1'b1;
        res_d.cull_reason = REASON_VIEW_MODEL;
      end
    end else if (kind2_q[KIND_PLAYER_BIT] && !special_q) begin
      res_d.culled      = 1'b1;
      res_d.cull_reason = REASON_PLAYER_MODEL;
    end else if (outside) begin
      res_d.culled      = 1'b1;
      res_d.cull_reason = REASON_FRUSTUM;
    end
  end

  // valid bits and handshake state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= 1'b0;
      v1_q   <= accept;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  // payload registers, loaded only with a live transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q  <= prod_d;
      rad1_q  <= in_i.sphere_radius;
      kind1_q <= in_i.model_kind;
    end
    if (v1_q) begin
      lhs_q   <= lhs_d;
      rad2_q  <= rad1_q;
      kind2_q <= kind1_q;
    end
    if (v2_q) begin
      res_q <= res_d;
    end
  end

`ifndef ASSERT_OFF
  // every result strobe comes from an earlier accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 3))
    else $error("result strobe without a matching transaction");

  // every accepted transaction yields a result strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 done_o)
    else $error("accepted transaction produced no result");

  // a drawn entity carries no reason and a culled one always does
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.culled == (res_o.cull_reason != REASON_NONE)))
    else $error("cull flag and reason disagree");

  // a view model is never frustum tested
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(in_i.model_kind[KIND_VIEW_BIT], 3))
      |-> (res_o.cull_reason != REASON_FRUSTUM))
    else $error("view model culled by frustum");
`endif

endmodule

FILE: tb/sv/tb.sv
// tb: self-checking testbench for entity_sphere_frustum_cull, directed cases then random phases
// depends on design/esfc_pkg.sv and design/entity_sphere_frustum_cull.sv
// verdicts are predicted in this file and compared per result transaction on done_o

module tb;
  import esfc_pkg::*;

  // model kind codes as carried on the input transaction
  localparam logic [KIND_W-1:0] KIND_ORDINARY    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VIEW        = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PLAYER      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_VIEW_PLAYER = 2'd3;

  localparam int MAX_REPORTS = 10;

  // shadow copy of the view registers
  typedef struct packed {
    logic [MAX_PLANES-1:0][PLANE_W-1:0] plane;
    logic [CLIP_W-1:0]                  clip;
    logic                               frustum_off;
    logic                               nonviewer;
    logic                               special;
  } view_cfg_t;

  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;
  logic                   start_i    = 1'b0;
  logic                   busy_o;
  esfc_in_t               in_i       = '0;
  logic                   done_o;
  esfc_out_t              res_o;
  logic                   cfg_we_i   = 1'b0;
  logic [REG_IDX_W-1:0]   cfg_idx_i  = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  view_cfg_t  shadow_cfg;
  esfc_out_t  pending_verdicts[$];
  int         fault_count = 0;

  entity_sphere_frustum_cull dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // register state after reset
  function automatic view_cfg_t reset_cfg();
    view_cfg_t c;
    c = '0;
    c.clip = CLIP_MASK_RST;
    return c;
  endfunction

  // pack a frustum plane word
  function automatic logic [PLANE_W-1:0] make_plane(input logic signed [NORM_W-1:0] nx,
                                                    input logic signed [NORM_W-1:0] ny,
                                                    input logic signed [NORM_W-1:0] nz,
                                                    input logic signed [DIST_W-1:0] plane_dist);
    return {plane_dist, nz, ny, nx};
  endfunction

  // cull verdict for one entity under a given view
  function automatic esfc_out_t predict_verdict(input esfc_in_t ent, input view_cfg_t c);
    esfc_out_t v;
    longint cx, cy, cz, rad, dot;
    logic signed [NORM_W-1:0] nx, ny, nz;
    logic signed [DIST_W-1:0] plane_dist;
    v.culled      = 1'b0;
    v.cull_reason = REASON_NONE;
    cx  = $signed(ent.centre_x);
    cy  = $signed(ent.centre_y);
    cz  = $signed(ent.centre_z);
    rad = ent.sphere_radius;
    if (ent.model_kind[KIND_VIEW_BIT]) begin
      if (c.nonviewer) begin
        v.culled      = 1'b1;
        v.cull_reason = REASON_VIEW_MODEL;
      end
    end else if (ent.model_kind[KIND_PLAYER_BIT] && !c.special) begin
      v.culled      = 1'b1;
      v.cull_reason = REASON_PLAYER_MODEL;
    end else if (!c.frustum_off) begin
      // wholly behind any enabled plane, tangent counts as behind
      for (int p = 0; p < NUM_PLANES; p++) begin
        if (!v.culled && c.clip[p]) begin
          nx         = c.plane[p][NX_LSB +: NORM_W];
          ny         = c.plane[p][NY_LSB +: NORM_W];
          nz         = c.plane[p][NZ_LSB +: NORM_W];
          plane_dist = c.plane[p][D_LSB +: DIST_W];
          dot  = cx * nx + cy * ny + cz * nz - longint'(plane_dist) * 2048;
          if (dot <= -(rad * 2048)) begin
            v.culled      = 1'b1;
            v.cull_reason = REASON_FRUSTUM;
          end
        end
      end
    end
    return v;
  endfunction

  // result checker: one verdict per strobe, oldest first
  always @(posedge clk_i) begin
    esfc_out_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("unexpected result: culled=%b reason=%0d", res_o.culled, res_o.cull_reason);
      end else begin
        want = pending_verdicts.pop_front();
        if (res_o.culled !== want.culled || res_o.cull_reason !== want.cull_reason) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("verdict mismatch: expected culled=%b reason=%0d, got culled=%b reason=%0d",
                     want.culled, want.cull_reason, res_o.culled, res_o.cull_reason);
        end
      end
    end
  end

  // send one entity transaction and record its verdict on acceptance
  task automatic send_entity(input esfc_in_t ent);
    start_i <= 1'b1;
    in_i    <= ent;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    pending_verdicts.push_back(predict_verdict(ent, shadow_cfg));
  endtask

  task automatic send_fields(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z, input logic [RAD_W-1:0] r,
                             input logic [KIND_W-1:0] kind);
    esfc_in_t ent;
    ent.centre_x      = x;
    ent.centre_y      = y;
    ent.centre_z      = z;
    ent.sphere_radius = r;
    ent.model_kind    = kind;
    send_entity(ent);
  endtask

  // random sender gap
  task automatic sender_gap(input bit gaps_on);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // stop sending and let the pipeline empty
  task automatic settle();
    start_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one register write, shadow follows at the same edge
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_CLIP_MASK: shadow_cfg.clip             = data[CLIP_W-1:0];
      REG_CULL_DIS:  shadow_cfg.frustum_off      = data[0];
      REG_NONVIEWER: shadow_cfg.nonviewer        = data[0];
      REG_SPECIAL:   shadow_cfg.special          = data[0];
      default:       shadow_cfg.plane[idx[1:0]]  = data;
    endcase
  endtask

  // write every register; unused upper bits carry noise
  task automatic load_config(input view_cfg_t c);
    logic [CFG_W-1:0] noise;
    settle();
    for (int p = 0; p < MAX_PLANES; p++)
      write_reg(REG_PLANE_0 + REG_IDX_W'(p), c.plane[p]);
    noise = CFG_W'({$urandom(), $urandom()});
    write_reg(REG_CLIP_MASK, {noise[CFG_W-1:CLIP_W], c.clip});
    noise = CFG_W'({$urandom(), $urandom()});
    write_reg(REG_CULL_DIS, {noise[CFG_W-1:1], c.frustum_off});
    noise = CFG_W'({$urandom(), $urandom()});
    write_reg(REG_NONVIEWER, {noise[CFG_W-1:1], c.nonviewer});
    noise = CFG_W'({$urandom(), $urandom()});
    write_reg(REG_SPECIAL, {noise[CFG_W-1:1], c.special});
    cfg_we_i <= 1'b0;
  endtask

  // random field generators, weighted towards the extremes
  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(COORD_W-1){1'b1}}};
      1:       return {1'b1, {(COORD_W-1){1'b0}}};
      2:       return $signed(COORD_W'($urandom_range(0, 2047))) - COORD_W'(1024);
      default: return COORD_W'($urandom());
    endcase
  endfunction

  function automatic logic signed [NORM_W-1:0] rand_norm();
    case ($urandom_range(0, 7))
      0:       return {1'b0, {(NORM_W-1){1'b1}}};
      1:       return {1'b1, {(NORM_W-1){1'b0}}};
      2:       return '0;
      default: return NORM_W'($urandom());
    endcase
  endfunction

  function automatic logic [RAD_W-1:0] rand_radius();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return RAD_W'($urandom() & ((32'd1 << $urandom_range(1, RAD_W)) - 32'd1));
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] rand_kind();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6)
      return KIND_ORDINARY;
    else if (pick < 8)
      return KIND_PLAYER;
    else if (pick == 8)
      return KIND_VIEW;
    return KIND_VIEW_PLAYER;
  endfunction

  // defaults after reset: zero planes cull only a zero radius
  task automatic test_reset_state();
    send_fields('0, '0, '0, '0, KIND_ORDINARY);
    send_fields('0, '0, '0, 23'd1, KIND_ORDINARY);
    send_fields('0, '0, '0, '0, KIND_VIEW);
    send_fields('0, '0, '0, '0, KIND_PLAYER);
    send_fields('0, '0, '0, '0, KIND_VIEW_PLAYER);
  endtask

  // view and player model rules under each view flag combination other than the reset one
  task automatic test_model_rules();
    view_cfg_t c;
    for (int v = 1; v < 4; v++) begin
      c = reset_cfg();
      c.nonviewer = v[0];
      c.special   = v[1];
      load_config(c);
      send_fields('0, '0, '0, '0, KIND_VIEW);
      send_fields('0, '0, '0, '0, KIND_PLAYER);
      send_fields('0, '0, '0, '0, KIND_VIEW_PLAYER);
    end
  endtask

  // tangent sphere, extreme fields, disable and empty clip mask
  task automatic test_frustum_extremes();
    view_cfg_t c;
    logic signed [COORD_W-1:0] cmax, cmin;
    cmax = {1'b0, {(COORD_W-1){1'b1}}};
    cmin = {1'b1, {(COORD_W-1){1'b0}}};

    // unit normal along x through the origin, only plane 0 enabled
    c = reset_cfg();
    c.plane[0] = make_plane(13'sd2048, 13'sd0, 13'sd0, 24'sd0);
    c.clip     = 4'b0001;
    load_config(c);
    send_fields(-24'sd256, '0, '0, 23'd256, KIND_ORDINARY);
    send_fields(-24'sd255, '0, '0, 23'd256, KIND_ORDINARY);

    // full-scale normals and distances
    c = reset_cfg();
    c.plane[0] = make_plane(13'sd4095, 13'sd4095, 13'sd4095, 24'sh7FFFFF);
    c.plane[1] = make_plane(-13'sd4096, -13'sd4096, -13'sd4096, 24'sh800000);
    c.plane[2] = '1;
    c.plane[3] = '1;
    load_config(c);
    send_fields(cmax, cmax, cmax, '1, KIND_ORDINARY);
    send_fields(cmin, cmin, cmin, '1, KIND_ORDINARY);
    send_fields(cmin, cmin, cmin, '0, KIND_ORDINARY);
    send_fields('0, '0, '0, '1, KIND_ORDINARY);

    c.frustum_off = 1'b1;
    load_config(c);
    send_fields(cmin, cmin, cmin, '0, KIND_ORDINARY);

    c.frustum_off = 1'b0;
    c.clip        = '0;
    load_config(c);
    send_fields(cmin, cmin, cmin, '0, KIND_ORDINARY);
  endtask

  // random phases, a fresh view per phase, last phase back to back
  task automatic test_random_traffic();
    localparam int PHASES = 9;
    localparam int PER_PHASE = 100;
    view_cfg_t c;
    esfc_in_t ent;
    bit gaps_on;
    for (int ph = 0; ph < PHASES; ph++) begin
      c = reset_cfg();
      for (int p = 0; p < MAX_PLANES; p++)
        c.plane[p] = make_plane(rand_norm(), rand_norm(), rand_norm(), rand_coord());
      if (ph == 0)
        c.clip = '1;
      else if (ph == 1)
        c.clip = '0;
      else
        c.clip = CLIP_W'($urandom());
      c.frustum_off = ($urandom_range(0, 5) == 0);
      c.nonviewer   = 1'($urandom());
      c.special     = ($urandom_range(0, 2) != 0);
      load_config(c);
      gaps_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PER_PHASE; n++) begin
        ent.centre_x      = rand_coord();
        ent.centre_y      = rand_coord();
        ent.centre_z      = rand_coord();
        ent.sphere_radius = rand_radius();
        ent.model_kind    = rand_kind();
        send_entity(ent);
        sender_gap(gaps_on);
      end
    end
  endtask

  // main sequence
  initial begin
    shadow_cfg = reset_cfg();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_model_rules();
    test_frustum_extremes();
    test_random_traffic();

    // drain the pipeline, bounded
    start_i <= 1'b0;
    repeat (200) begin
      if (pending_verdicts.size() != 0) @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      $display("%0d verdicts never arrived", pending_verdicts.size());
      fault_count += pending_verdicts.size();
    end

    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
